@@ hw/rtl/fully_connected_layer_mac_defines.svh @@
// Assertion macros of the fully connected layer MAC top level.
`ifndef FULLY_CONNECTED_LAYER_MAC_DEFINES_SVH
`define FULLY_CONNECTED_LAYER_MAC_DEFINES_SVH

`ifndef SYNTH
// Property checked at every clock edge outside reset.
`define FCLM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("fclm assertion failed");
// Implication checked in the cycle after the trigger, outside reset.
`define FCLM_ASSERT_NEXT(lbl, clk, rst, trig, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("fclm assertion failed");
`else
`define FCLM_ASSERT(lbl, clk, rst, prop)
`define FCLM_ASSERT_NEXT(lbl, clk, rst, trig, cons)
`endif

`endif

@@ hw/rtl/fclm_pkg.sv @@
// Types, codes and defaults of the fully connected layer MAC block.
package fclm_pkg;

   localparam int DATA_W    = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int LEN_W     = 7;
   localparam int ACC_W     = PROD_W + LEN_W + 1;
   localparam int IDX_W     = 6;
   localparam int CSR_IDX_W = 2;

   localparam int DEF_MAX_IN    = 64;
   localparam int DEF_MAX_OUT   = 64;
   localparam int DEF_FRAC_BITS = 8;

   localparam logic [1:0] REQ_WEIGHT = 2'd0;
   localparam logic [1:0] REQ_BIAS   = 2'd1;
   localparam logic [1:0] REQ_INPUT  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_IN_LEN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LEN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_EN  = 2'd2;

   // Tag that travels beside each MAC step through the datapath.
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last;
      logic             out_end;
      logic [IDX_W-1:0] row;
   } mac_tag_type;

endpackage

@@ hw/rtl/fclm_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module fclm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/fclm_mac.sv @@
// Multiply-accumulate datapath: product, accumulate, bias add, scale and clip.
module fclm_mac import fclm_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  mac_tag_type       issue_tag,
   input  logic [DATA_W-1:0] weight_data,
   input  logic [DATA_W-1:0] input_data,
   input  logic [DATA_W-1:0] bias_data,
   input  logic              bias_en,
   output logic              rsp_valid,
   output logic [IDX_W-1:0]  rsp_out_index,
   output logic [DATA_W-1:0] rsp_out_value,
   output logic              rsp_sat_flag,
   output logic              rsp_out_last
);

   mac_tag_type              tag_s1_ff, tag_s2_ff, tag_s3_ff, tag_s4_ff;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic [DATA_W-1:0]        bias_s2_ff, bias_s3_ff;
   logic signed [ACC_W-1:0]  acc_in, acc_ff;
   logic signed [ACC_W-1:0]  bias_ext;
   logic signed [ACC_W-1:0]  sum_in, sum_ff;
   logic signed [ACC_W-1:0]  scaled;
   logic [ACC_W-DATA_W:0]    high_bits;
   logic                     sat_in;
   logic [DATA_W-1:0]        value_in;
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_index_ff;
   logic [DATA_W-1:0]        rsp_value_ff;
   logic                     rsp_sat_ff;
   logic                     rsp_last_ff;

   assign prod_in  = $signed(weight_data) * $signed(input_data);
   assign acc_in   = (tag_s2_ff.first ? '0 : acc_ff) +
                     {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign bias_ext = $signed({{(ACC_W-DATA_W){bias_s3_ff[DATA_W-1]}}, bias_s3_ff})
                     <<< FRAC_BITS;
   assign sum_in   = bias_en ? (acc_ff + bias_ext) : acc_ff;

   // Arithmetic shift rounds toward minus infinity; clip when the high bits disagree.
   assign scaled    = sum_ff >>> FRAC_BITS;
   assign high_bits = scaled[ACC_W-1:DATA_W-1];
   assign sat_in    = !((&high_bits) || !(|high_bits));
   always_comb begin
      if (!sat_in) begin
         value_in = scaled[DATA_W-1:0];
      end else if (scaled[ACC_W-1]) begin
         value_in = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         value_in = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_s1_ff    <= '0;
         tag_s2_ff    <= '0;
         tag_s3_ff    <= '0;
         tag_s4_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag_s1_ff    <= issue_tag;
         tag_s2_ff    <= tag_s1_ff;
         tag_s3_ff    <= tag_s2_ff;
         tag_s4_ff    <= tag_s3_ff.last ? tag_s3_ff : '0;
         rsp_valid_ff <= tag_s4_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      bias_s2_ff   <= bias_data;
      bias_s3_ff   <= bias_s2_ff;
      if (tag_s2_ff.valid) begin
         acc_ff <= acc_in;
      end
      sum_ff       <= sum_in;
      rsp_index_ff <= tag_s4_ff.row;
      rsp_value_ff <= value_in;
      rsp_sat_ff   <= sat_in;
      rsp_last_ff  <= tag_s4_ff.out_end;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_sat_flag  = rsp_sat_ff;
   assign rsp_out_last  = rsp_last_ff;

endmodule

@@ hw/rtl/fully_connected_layer_mac.sv @@
// Top level of the fully connected layer MAC engine, y = W*x + b.
//
// A beat on the request port is taken when start is high and busy is low.
// Weight writes, bias writes and input elements without the last
// mark raise no busy. An input element with the last mark raises busy
// and starts one pass over the stored layer: one multiply-accumulate per
// cycle on a single shared 16x16 multiplier, fed from the weight RAM's
// one read port, so a pass issues n_in * n_out steps and busy stays high
// until the last result row has left, after which the next request is
// taken. Results leave in row order, one beat per row, each marked by
// rsp_valid for exactly one cycle; the receiver cannot stall, so capture
// every strobe. With n_in of 1 rows come back to back. The configuration
// port is ready only while busy is low. Stores come up undefined after reset
// and need no clearing pass: write every weight, bias and input used.
`include "fully_connected_layer_mac_defines.svh"

module fully_connected_layer_mac import fclm_pkg::*; #(
   parameter int MAX_IN    = DEF_MAX_IN,
   parameter int MAX_OUT   = DEF_MAX_OUT,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_type,
   input  logic [IDX_W-1:0]     req_row_index,
   input  logic [IDX_W-1:0]     req_col_index,
   input  logic [DATA_W-1:0]    req_data_value,
   input  logic                 req_vec_last,
   // result channel
   output logic                 rsp_valid,
   output logic [IDX_W-1:0]     rsp_out_index,
   output logic [DATA_W-1:0]    rsp_out_value,
   output logic                 rsp_sat_flag,
   output logic                 rsp_out_last,
   // configuration channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]     csr_wdata
);

   localparam int IAW = MAX_IN > 1 ? $clog2(MAX_IN) : 1;
   localparam int OAW = MAX_OUT > 1 ? $clog2(MAX_OUT) : 1;
   localparam int WAW = (MAX_IN * MAX_OUT) > 1 ? $clog2(MAX_IN * MAX_OUT) : 1;
   localparam logic [10:0] MAX_IN_W  = 11'(MAX_IN);
   localparam logic [10:0] MAX_OUT_W = 11'(MAX_OUT);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] r_ff, r_in;
   logic [LEN_W-1:0] c_ff, c_in;
   logic [LEN_W-1:0] n_in_ff, n_in_in;
   logic [LEN_W-1:0] n_out_ff, n_out_in;
   logic [LEN_W-1:0] in_len_ff, out_len_ff;
   logic             bias_en_ff;

   logic        req_fire, go, row_ok, col_ok;
   logic        col_end, row_end;
   mac_tag_type issue_tag;
   logic        w_wr_en, b_wr_en, x_wr_en;
   logic [WAW-1:0] w_wr_addr, w_rd_addr;
   logic [DATA_W-1:0] w_rd_data, b_rd_data, x_rd_data;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;
   assign req_fire  = start && !busy;
   assign go        = req_fire && (req_type == REQ_INPUT) && req_vec_last;

   // Drop writes that land outside the stores.
   assign row_ok = ({5'd0, req_row_index} < MAX_OUT_W);
   assign col_ok = ({5'd0, req_col_index} < MAX_IN_W);

   assign w_wr_en = req_fire && (req_type == REQ_WEIGHT) && row_ok && col_ok;
   assign b_wr_en = req_fire && (req_type == REQ_BIAS) && row_ok;
   assign x_wr_en = req_fire && (req_type == REQ_INPUT) && col_ok;

   assign w_wr_addr = WAW'(int'(req_row_index) * MAX_IN + int'(req_col_index));
   assign w_rd_addr = WAW'(int'(r_ff) * MAX_IN + int'(c_ff));

   // Clamp the lengths to 1..max once per pass.
   always_comb begin
      priority if (in_len_ff == '0) begin
         n_in_in = LEN_W'(1);
      end else if ({4'd0, in_len_ff} > MAX_IN_W) begin
         n_in_in = LEN_W'(MAX_IN);
      end else begin
         n_in_in = in_len_ff;
      end
      priority if (out_len_ff == '0) begin
         n_out_in = LEN_W'(1);
      end else if ({4'd0, out_len_ff} > MAX_OUT_W) begin
         n_out_in = LEN_W'(MAX_OUT);
      end else begin
         n_out_in = out_len_ff;
      end
   end

   assign col_end = (c_ff == n_in_ff - LEN_W'(1));
   assign row_end = ({1'b0, r_ff} == n_out_ff - LEN_W'(1));

   always_comb begin
      issue_tag.valid   = (state_ff == ST_RUN);
      issue_tag.first   = (c_ff == '0);
      issue_tag.last    = col_end;
      issue_tag.out_end = row_end;
      issue_tag.row     = r_ff;
   end

   // Sequencer: walk columns inside rows, then wait for the pipeline to empty.
   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      unique case (state_ff)
         ST_IDLE: begin
            r_in = '0;
            c_in = '0;
            if (go) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (col_end) begin
               c_in = '0;
               r_in = r_ff + IDX_W'(1);
               if (row_end) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               c_in = c_ff + LEN_W'(1);
            end
         end
         ST_DRAIN: begin
            if (rsp_valid && rsp_out_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         r_ff       <= '0;
         c_ff       <= '0;
         n_in_ff    <= LEN_W'(1);
         n_out_ff   <= LEN_W'(1);
         in_len_ff  <= LEN_W'(64);
         out_len_ff <= LEN_W'(64);
         bias_en_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         if (go) begin
            n_in_ff  <= n_in_in;
            n_out_ff <= n_out_in;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_IN_LEN:  in_len_ff  <= csr_wdata;
               CSR_OUT_LEN: out_len_ff <= csr_wdata;
               CSR_BIAS_EN: bias_en_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   fclm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_IN * MAX_OUT)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (req_data_value),
      .rd_addr (w_rd_addr),
      .rd_data (w_rd_data)
   );

   fclm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_OUT)) u_bias_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (OAW'(req_row_index)),
      .wr_data (req_data_value),
      .rd_addr (OAW'(r_ff)),
      .rd_data (b_rd_data)
   );

   fclm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_IN)) u_input_ram (
      .clock   (clock),
      .wr_en   (x_wr_en),
      .wr_addr (IAW'(req_col_index)),
      .wr_data (req_data_value),
      .rd_addr (IAW'(c_ff)),
      .rd_data (x_rd_data)
   );

   fclm_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock         (clock),
      .reset         (reset),
      .issue_tag     (issue_tag),
      .weight_data   (w_rd_data),
      .input_data    (x_rd_data),
      .bias_data     (b_rd_data),
      .bias_en       (bias_en_ff),
      .rsp_valid     (rsp_valid),
      .rsp_out_index (rsp_out_index),
      .rsp_out_value (rsp_out_value),
      .rsp_sat_flag  (rsp_sat_flag),
      .rsp_out_last  (rsp_out_last)
   );

   `FCLM_ASSERT(a_rsp_only_busy, clock, reset, !rsp_valid || busy)
   `FCLM_ASSERT_NEXT(a_go_runs, clock, reset, go, state_ff == ST_RUN)
   `FCLM_ASSERT_NEXT(a_last_frees, clock, reset, rsp_valid && rsp_out_last, !busy)
   `FCLM_ASSERT(a_col_bound, clock, reset, state_ff != ST_RUN || c_ff < n_in_ff)

endmodule

@@ tb/sv/fully_connected_layer_mac_tb.sv @@
// Self-checking testbench of the fully connected layer MAC engine.
module fully_connected_layer_mac_tb;
   import fclm_pkg::*;

   // Codes the block must ignore: the spare request type and register index.
   localparam logic [1:0]           REQ_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int     ITEM_TARGET   = 420;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     TAIL_CYCLES   = 32;
   localparam int     STALL_LIMIT   = 5000;
   localparam int     N_DIRECTED    = 27;
   localparam longint SAT_HI        = 2 ** (DATA_W - 1) - 1;
   localparam longint SAT_LO        = -(2 ** (DATA_W - 1));

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   // One row of the directed table: a request beat or a register write.
   // Where pinned is set, the single result row is typed in by hand.
   typedef struct packed {
      row_kind_type           kind;
      logic [1:0]             typ;
      logic [IDX_W-1:0]       row_i;
      logic [IDX_W-1:0]       col_i;
      logic [DATA_W-1:0]      value;
      logic                   mark;
      logic [CSR_IDX_W-1:0]   reg_idx;
      logic [LEN_W-1:0]       reg_data;
      logic                   pinned;
      logic [DATA_W-1:0]      pin_value;
      logic                   pin_sat;
   } stim_row_type;

   typedef struct packed {
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] value;
      logic              sat;
      logic              last;
   } row_result_type;

   logic                 clock;
   logic                 reset          = 1'b1;
   logic                 start          = 1'b0;
   logic                 busy;
   logic [1:0]           req_type       = REQ_WEIGHT;
   logic [IDX_W-1:0]     req_row_index  = '0;
   logic [IDX_W-1:0]     req_col_index  = '0;
   logic [DATA_W-1:0]    req_data_value = '0;
   logic                 req_vec_last   = 1'b0;
   logic                 rsp_valid;
   logic [IDX_W-1:0]     rsp_out_index;
   logic [DATA_W-1:0]    rsp_out_value;
   logic                 rsp_sat_flag;
   logic                 rsp_out_last;
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index      = CSR_IN_LEN;
   logic [LEN_W-1:0]     csr_wdata      = '0;

   fully_connected_layer_mac uut (.*);

   // Mirror of the layer: stores, which entries hold a value, and registers.
   logic signed [DATA_W-1:0] weight_mem [DEF_MAX_OUT][DEF_MAX_IN];
   logic signed [DATA_W-1:0] bias_mem   [DEF_MAX_OUT];
   logic signed [DATA_W-1:0] input_mem  [DEF_MAX_IN];
   bit                       weight_seen [DEF_MAX_OUT][DEF_MAX_IN];
   bit                       bias_seen   [DEF_MAX_OUT];
   bit                       input_seen  [DEF_MAX_IN];
   logic [LEN_W-1:0]         cfg_in_len  = LEN_W'(DEF_MAX_IN);
   logic [LEN_W-1:0]         cfg_out_len = LEN_W'(DEF_MAX_OUT);
   logic                     cfg_bias_en = 1'b1;

   // Output rows still owed by the block, oldest first.
   row_result_type pending_rows [$];

   bit gaps_on;
   int beats_sent, vectors_run, results_checked, sat_rows, reg_writes;
   int fail_count, quiet_cycles;

   // Directed table: basic product with bias, marks and spare type ignored,
   // saturation both ways, exact minimum, floor rounding of negatives,
   // bias disabled, spare register index, zero input length.
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{ROW_CSR, REQ_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, CSR_IN_LEN,  7'd1,  1'b0, 16'h0000, 1'b0},
      '{ROW_CSR, REQ_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, CSR_OUT_LEN, 7'd1,  1'b0, 16'h0000, 1'b0},
      '{ROW_CSR, REQ_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, CSR_BIAS_EN, 7'h01, 1'b0, 16'h0000, 1'b0},
      '{ROW_REQ, REQ_WEIGHT, 6'd0,  6'd0,  16'h0100, 1'b0, CSR_IN_LEN,  7'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_REQ, REQ_BIAS,   6'd0,  6'd63, 16'h0080, 1'b1, CSR_IN_LEN,  7'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_REQ, REQ_UNUSED, 6'd63, 6'd63, 16'hFFFF, 1'b1, CSR_IN_LEN,  7'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_REQ, REQ_INPUT,  6'd63, 6'd0,  16'h0200, 1'b1, CSR_IN_LEN,  7'd0,  1'b1, 16'h0280, 1'b0},
      '{ROW_REQ, REQ_WEIGHT, 6'd0,  6'd0,  16'h7FFF, 1'b0, CSR_IN_LEN,  7'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_REQ, REQ_INPUT,  6'd0,  6'd0,  16'h7FFF, 1'b1, CSR_IN_LEN,  7'd0,  1'b1, 16'h7FFF, 1'b1},
      '{ROW_REQ, REQ_INPUT,  6'd0,  6'd0,  16'h8000, 1'b1, CSR_IN_LEN,  7'd0,  1'b1, 16'h8000, 1'b1},
      '{ROW_REQ, REQ_WEIGHT, 6'd0,  6'd0,  16'h8000, 1'b0, CSR_IN_LEN,  7'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_REQ, REQ_INPUT,  6'd0,  6'd0,  16'h8000, 1'b1, CSR_IN_LEN,  7'd0,  1'b1, 16'h7FFF, 1'b1},
      '{ROW_REQ, REQ_BIAS,   6'd0,  6'd0,  16'h8000, 1'b0, CSR_IN_LEN,  7'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_REQ, REQ_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, CSR_IN_LEN,  7'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_REQ, REQ_INPUT,  6'd0,  6'd0,  16'h0000, 1'b1, CSR_IN_LEN,  7'd0,  1'b1, 16'h8000, 1'b0},
      '{ROW_REQ, REQ_BIAS,   6'd0,  6'd0,  16'h7FFF, 1'b0, CSR_IN_LEN,  7'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_REQ, REQ_INPUT,  6'd0,  6'd0,  16'h0000, 1'b1, CSR_IN_LEN,  7'd0,  1'b1, 16'h7FFF, 1'b0},
      '{ROW_REQ, REQ_WEIGHT, 6'd0,  6'd0,  16'h0001, 1'b0, CSR_IN_LEN,  7'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_REQ, REQ_BIAS,   6'd0,  6'd0,  16'h0000, 1'b0, CSR_IN_LEN,  7'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_REQ, REQ_INPUT,  6'd0,  6'd0,  16'hFFFF, 1'b1, CSR_IN_LEN,  7'd0,  1'b1, 16'hFFFF, 1'b0},
      '{ROW_REQ, REQ_INPUT,  6'd0,  6'd0,  16'h0001, 1'b1, CSR_IN_LEN,  7'd0,  1'b1, 16'h0000, 1'b0},
      '{ROW_CSR, REQ_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, CSR_BIAS_EN, 7'h7E, 1'b0, 16'h0000, 1'b0},
      '{ROW_REQ, REQ_BIAS,   6'd0,  6'd0,  16'h7FFF, 1'b0, CSR_IN_LEN,  7'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_REQ, REQ_INPUT,  6'd0,  6'd0,  16'h0100, 1'b1, CSR_IN_LEN,  7'd0,  1'b1, 16'h0001, 1'b0},
      '{ROW_CSR, REQ_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, CSR_UNUSED,  7'h7F, 1'b0, 16'h0000, 1'b0},
      '{ROW_CSR, REQ_WEIGHT, 6'd0,  6'd0,  16'h0000, 1'b0, CSR_IN_LEN,  7'd0,  1'b0, 16'h0000, 1'b0},
      '{ROW_REQ, REQ_INPUT,  6'd0,  6'd5,  16'h1234, 1'b1, CSR_IN_LEN,  7'd0,  1'b0, 16'h0000, 1'b0}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Effective length: zero acts as one, anything past the store size is clipped.
   function automatic int clamp_features(input logic [LEN_W-1:0] raw, input int limit);
      if (raw == '0) return 1;
      if (int'(raw) > limit) return limit;
      return int'(raw);
   endfunction

   function automatic logic [IDX_W-1:0] rand_idx();
      return IDX_W'($urandom_range(0, 2 ** IDX_W - 1));
   endfunction

   // Mostly small values so that sums stay in range; some large ones to
   // drive saturation, and the corner codes now and then.
   function automatic logic [DATA_W-1:0] pick_value();
      int               sel;
      logic [DATA_W-1:0] v;
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
         v = DATA_W'($urandom_range(0, 1023));
         v = v - 16'd512;
      end else if (sel < 8) begin
         v = DATA_W'($urandom_range(0, 8191));
         v = v - 16'd4096;
      end else if (sel == 8) begin
         case ($urandom_range(0, 3))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2:       v = 16'h0000;
            default: v = 16'hFFFF;
         endcase
      end else begin
         v = DATA_W'($urandom());
      end
      return v;
   endfunction

   // Apply one accepted beat to the mirror; a marked input element runs the
   // whole layer and queues one output row per active row.
   task automatic layer_mirror_step(input logic [1:0] typ, input logic [IDX_W-1:0] row_i,
                                    input logic [IDX_W-1:0] col_i,
                                    input logic [DATA_W-1:0] value, input logic mark);
      int             n_in, n_out, r, c;
      longint         acc;
      row_result_type res;
      case (typ)
         REQ_WEIGHT: begin
            weight_mem[row_i][col_i]  = value;
            weight_seen[row_i][col_i] = 1'b1;
         end
         REQ_BIAS: begin
            bias_mem[row_i]  = value;
            bias_seen[row_i] = 1'b1;
         end
         REQ_INPUT: begin
            input_mem[col_i]  = value;
            input_seen[col_i] = 1'b1;
            if (mark) begin
               n_in  = clamp_features(cfg_in_len, DEF_MAX_IN);
               n_out = clamp_features(cfg_out_len, DEF_MAX_OUT);
               vectors_run++;
               for (r = 0; r < n_out; r++) begin
                  acc = 0;
                  for (c = 0; c < n_in; c++)
                     acc += longint'(weight_mem[r][c]) * longint'(input_mem[c]);
                  // Align the bias to the product scale before adding.
                  if (cfg_bias_en)
                     acc += longint'(bias_mem[r]) <<< DEF_FRAC_BITS;
                  // Arithmetic shift rounds toward minus infinity.
                  acc = acc >>> DEF_FRAC_BITS;
                  res.index = IDX_W'(r);
                  res.last  = (r == n_out - 1);
                  if (acc > SAT_HI) begin
                     res.value = 16'h7FFF;
                     res.sat   = 1'b1;
                  end else if (acc < SAT_LO) begin
                     res.value = 16'h8000;
                     res.sat   = 1'b1;
                  end else begin
                     res.value = DATA_W'(acc);
                     res.sat   = 1'b0;
                  end
                  pending_rows.push_back(res);
               end
            end
         end
         default: ;
      endcase
   endtask

   // Present one beat and hold it until the block takes it. An idle burst
   // may come first. Return in the accepting step with start still high, so
   // the caller either presents the next beat or drops start.
   task automatic send_beat(input logic [1:0] typ, input logic [IDX_W-1:0] row_i,
                            input logic [IDX_W-1:0] col_i,
                            input logic [DATA_W-1:0] value, input logic mark);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= typ;
      req_row_index  <= row_i;
      req_col_index  <= col_i;
      req_data_value <= value;
      req_vec_last   <= mark;
      do @(posedge clock); while (busy !== 1'b0);
      layer_mirror_step(typ, row_i, col_i, value, mark);
      if (typ != REQ_UNUSED) beats_sent++;
   endtask

   // Drain every owed row and let the block settle, then write one register.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
      start <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (idx)
         CSR_IN_LEN:  cfg_in_len  = data;
         CSR_OUT_LEN: cfg_out_len = data;
         CSR_BIAS_EN: cfg_bias_en = data[0];
         default: ;
      endcase
      reg_writes++;
   endtask

   // Random beat that never starts a pass: any type, any address, marks on
   // writes, and the spare request type.
   task automatic noise_beat();
      logic [1:0] typ;
      typ = 2'($urandom_range(0, 3));
      send_beat(typ, rand_idx(), rand_idx(), pick_value(),
                (typ == REQ_INPUT) ? 1'b0 : 1'($urandom_range(0, 1)));
   endtask

   // Write every weight, bias and input that the next pass reads and that
   // holds no value yet, so no pass ever reads an empty entry.
   task automatic fill_layer();
      int n_in, n_out, r, c;
      n_in  = clamp_features(cfg_in_len, DEF_MAX_IN);
      n_out = clamp_features(cfg_out_len, DEF_MAX_OUT);
      for (r = 0; r < n_out; r++)
         for (c = 0; c < n_in; c++)
            if (!weight_seen[r][c])
               send_beat(REQ_WEIGHT, IDX_W'(r), IDX_W'(c), pick_value(),
                         1'($urandom_range(0, 1)));
      if (cfg_bias_en)
         for (r = 0; r < n_out; r++)
            if (!bias_seen[r])
               send_beat(REQ_BIAS, IDX_W'(r), rand_idx(), pick_value(), 1'b0);
      for (c = 0; c < n_in; c++)
         if (!input_seen[c])
            send_beat(REQ_INPUT, rand_idx(), IDX_W'(c), pick_value(), 1'b0);
   endtask

   task automatic flag_error(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR at %0t: %s", $time, msg);
   endtask

   // Result checker: every strobe must match the oldest owed row.
   always @(posedge clock) begin : check_rows
      row_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_rows.size() == 0) begin
            flag_error($sformatf("unexpected row idx %0d val %h sat %b last %b",
                                 rsp_out_index, rsp_out_value, rsp_sat_flag, rsp_out_last));
         end else begin
            want = pending_rows.pop_front();
            results_checked++;
            if (want.sat) sat_rows++;
            if (rsp_out_index !== want.index || rsp_out_value !== want.value ||
                rsp_sat_flag !== want.sat || rsp_out_last !== want.last)
               flag_error($sformatf({"row mismatch: want idx %0d val %h sat %b last %b,",
                                     " got idx %0d val %h sat %b last %b"},
                                    want.index, want.value, want.sat, want.last,
                                    rsp_out_index, rsp_out_value, rsp_sat_flag,
                                    rsp_out_last));
         end
      end
   end

   // Watchdog: count cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int phase_no, nvec, sel, raw_in, raw_out, tmp;
      repeat (10) @(posedge clock);
      reset   <= 1'b0;
      gaps_on = 1'b1;

      // Walk the directed table; pinned rows replace the mirror's row.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
         end else begin
            send_beat(directed_rows[i].typ, directed_rows[i].row_i, directed_rows[i].col_i,
                      directed_rows[i].value, directed_rows[i].mark);
            if (directed_rows[i].pinned) begin
               pending_rows[pending_rows.size() - 1].value = directed_rows[i].pin_value;
               pending_rows[pending_rows.size() - 1].sat   = directed_rows[i].pin_sat;
            end
         end
      end

      // Random phases: pick a layer shape, then run a few vectors through it.
      // The first phases hit the length extremes with the other length tiny.
      phase_no = 0;
      while (beats_sent < ITEM_TARGET) begin
         // Keep the closing stretch free of sender gaps.
         gaps_on = (beats_sent < ITEM_TARGET - 60) && ($urandom_range(0, 3) != 0);
         case (phase_no)
            0: begin raw_in = 0;   raw_out = 127; end
            1: begin raw_in = 127; raw_out = 0;   end
            2: begin raw_in = 64;  raw_out = 1;   end
            3: begin raw_in = 1;   raw_out = 64;  end
            default: begin
               sel = $urandom_range(0, 9);
               if (sel < 7) begin
                  raw_in  = $urandom_range(1, 8);
                  raw_out = $urandom_range(1, 8);
               end else if (sel < 9) begin
                  raw_in  = $urandom_range(1, 16);
                  raw_out = $urandom_range(1, 16);
               end else begin
                  raw_in  = $urandom_range(0, 1) ? 0 : $urandom_range(64, 127);
                  raw_out = $urandom_range(1, 2);
                  if ($urandom_range(0, 1)) begin
                     tmp     = raw_in;
                     raw_in  = raw_out;
                     raw_out = tmp;
                  end
               end
            end
         endcase
         // Now and then keep the old shape and stream straight on.
         if (phase_no < 4 || $urandom_range(0, 3) != 0) begin
            write_reg(CSR_IN_LEN, LEN_W'(raw_in));
            write_reg(CSR_OUT_LEN, LEN_W'(raw_out));
            if ($urandom_range(0, 1))
               write_reg(CSR_BIAS_EN, LEN_W'($urandom_range(0, 127)));
            if ($urandom_range(0, 7) == 0)
               write_reg(CSR_UNUSED, LEN_W'($urandom_range(0, 127)));
         end
         nvec = $urandom_range(1, 3);
         repeat (nvec) begin
            repeat ($urandom_range(0, 6)) noise_beat();
            fill_layer();
            send_beat(REQ_INPUT, rand_idx(), rand_idx(), pick_value(), 1'b1);
         end
         phase_no++;
      end

      // Drop start, wait out every owed row, then give stray rows time to show.
      start <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("summary: %0d request beats, %0d passes over %0d shapes, %0d register writes",
               beats_sent, vectors_run, phase_no, reg_writes);
      $display("summary: %0d rows checked, %0d saturated, %0d errors",
               results_checked, sat_rows, fail_count);
      if (fail_count == 0 && pending_rows.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
